// ----- rtl/core/hfir_pkg.sv -----
// ----------------------------------------------------------------------------
// hfir_pkg
// Shared widths, types and constants of the Hilbert transformer FIR.
// ----------------------------------------------------------------------------
package hfir_pkg;

    localparam int TAPS     = 33;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = PROD_W + 8;
    localparam int FRAC_W   = 15;

    localparam longint HILB_SCALED_INV_PI = 64'sd208607567;
    localparam longint HILB_SCALE         = 64'sd10000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef struct packed {
        logic accept;
        logic m_ready;
    } hfir_ctl_t;

endpackage

// ----- rtl/core/hilbert_fir_filter.sv -----
// ----------------------------------------------------------------------------
// hilbert_fir_filter
// Streaming Hilbert transformer built as a transposed FIR chain of tap cells.
//
//   Channel   Ports                           Dir   Moves
//   input     s_valid s_ready s_sample_in     in    one sample request
//   result    m_valid m_ready m_sample_out    out   one filtered sample
//
// One sample is taken every cycle unless the output stalls; its result goes
// into the output register on acceptance and is offered from the following cycle.
// Each tap cell multiplies the new sample by its constant coefficient and
// adds the partial sum of its neighbor.
// Reset clears all partial sums, so missing history counts as zero.
// A stalled result holds the whole chain; a new sample is taken in the same
// cycle in which the waiting result is taken.
// ----------------------------------------------------------------------------
module hilbert_fir_filter import hfir_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  sample_t s_sample_in,
    output logic    m_valid,
    input  logic    m_ready,
    output sample_t m_sample_out
);

    sample_t   coef_tab [TAPS];
    acc_t      cell_sum [1:TAPS];
    prod_t     head_prod;
    acc_t      head_acc;
    hfir_ctl_t ctl;

    assign s_ready = !m_valid || m_ready;
    assign ctl     = {s_valid && s_ready, m_ready};

    for (genvar j = 0; j < TAPS; j++) begin : g_coef
        localparam longint K   = longint'(j) - longint'(TAPS / 2);
        localparam longint A   = (K < 0) ? -K : K;
        localparam longint DIV = HILB_SCALE * ((A == 0) ? 64'sd1 : A);
        localparam longint MAG = ((K % 2) == 0) ? 64'sd0 :
                                 (HILB_SCALED_INV_PI + (HILB_SCALE / 2) * A) / DIV;
        localparam longint VAL = (K < 0) ? -MAG : MAG;
        assign coef_tab[j] = sample_t'(VAL);
    end

    assign cell_sum[TAPS] = '0;

    for (genvar j = 1; j < TAPS; j++) begin : g_cell
        hfir_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (ctl.accept),
            .coef    (coef_tab[j]),
            .x       (s_sample_in),
            .sum_in  (cell_sum[j+1]),
            .sum_out (cell_sum[j])
        );
    end

    assign head_prod = coef_tab[0] * s_sample_in;
    assign head_acc  = cell_sum[1] + acc_t'(head_prod);

    hfir_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .acc          (head_acc),
        .m_valid      (m_valid),
        .m_sample_out (m_sample_out)
    );

endmodule

// ----- rtl/core/hfir_cell.sv -----
// ----------------------------------------------------------------------------
// hfir_cell
// One tap of the transposed filter: adds its product to the partial sum
// handed on by its neighbor and registers the result.
// ----------------------------------------------------------------------------
module hfir_cell import hfir_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  sample_t coef,
    input  sample_t x,
    input  acc_t    sum_in,
    output acc_t    sum_out
);

    prod_t prod;
    acc_t  sum_reg;
    acc_t  sum_next;

    assign prod     = coef * x;
    assign sum_next = sum_in + acc_t'(prod);
    assign sum_out  = sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (en) begin
            sum_reg <= sum_next;
        end
    end

endmodule

// ----- rtl/core/hfir_out.sv -----
// ----------------------------------------------------------------------------
// hfir_out
// Rounds the full sum to Q1.15, saturates it and holds it for the
// result channel.
// ----------------------------------------------------------------------------
module hfir_out import hfir_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  hfir_ctl_t ctl,
    input  acc_t      acc,
    output logic      m_valid,
    output sample_t   m_sample_out
);

    localparam int QUOT_W = ACC_W - FRAC_W;

    acc_t                     rounded;
    logic signed [QUOT_W-1:0] quot;
    sample_t                  sat;
    logic                     valid_reg;
    logic                     valid_next;
    sample_t                  sample_reg;

    assign rounded = acc + acc_t'(1 <<< (FRAC_W - 1));
    assign quot    = rounded[ACC_W-1:FRAC_W];

    always_comb begin
        if (quot > 32767) begin
            sat = 16'sh7fff;
        end else if (quot < -32768) begin
            sat = 16'sh8000;
        end else begin
            sat = quot[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (ctl.accept) begin
            valid_next = 1'b1;
        end else if (ctl.m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            sample_reg <= sat;
        end
    end

    assign m_valid      = valid_reg;
    assign m_sample_out = sample_reg;

endmodule

// ----- rtl/core/hfir_checker.sv -----
// ----------------------------------------------------------------------------
// hfir_checker
// Port-level checks of the Hilbert transformer, bound to the top level.
// ----------------------------------------------------------------------------
module hfir_checker import hfir_pkg::*; (
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input sample_t m_sample_out
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("Accepted request produced no result.");

    a_ready_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("Input stalled while the output could move.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sample_out)))
        else $error("Stalled result changed or vanished.");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !s_valid) |=> !m_valid)
        else $error("Result appeared without a request.");

endmodule

bind hilbert_fir_filter hfir_checker u_hfir_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out)
);
